// ===== design/frca_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the cache admission core.
package frca_pkg;

    localparam int NUM_IDS_DEF     = 256;
    localparam int CACHE_SLOTS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int FUNC_W = 2;
    localparam int ITEM_W = 8;

    // Operation codes of an input word
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EVAL,
        ST_SCAN,
        ST_DRAIN,
        ST_RESOLVE,
        ST_ADMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic eval;
        logic scan_init;
        logic scan_issue;
        logic resolve;
        logic admit_new;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic eval_scan;
        logic scan_last;
        logic pipe_busy;
        logic resolve_admit;
    } status_t;

endpackage

// ===== design/frca_in_if.sv =====
// Input channel: one operation word per handshake.
interface frca_in_if;
    logic                        valid;
    logic                        ready;
    logic [frca_pkg::FUNC_W-1:0] func;
    logic [frca_pkg::ITEM_W-1:0] item_id;

    modport source (output valid, output func, output item_id, input ready);
    modport sink   (input valid, input func, input item_id, output ready);
endinterface

// ===== design/frca_out_if.sv =====
// Result channel: one fetch/release word per handshake.
interface frca_out_if;
    logic                        valid;
    logic                        ready;
    logic                        fetch_valid;
    logic [frca_pkg::ITEM_W-1:0] fetch_id;
    logic                        release_valid;
    logic [frca_pkg::ITEM_W-1:0] release_id;

    modport source (output valid, output fetch_valid, output fetch_id,
                    output release_valid, output release_id, input ready);
    modport sink   (input valid, input fetch_valid, input fetch_id,
                    input release_valid, input release_id, output ready);
endinterface

// ===== design/frequency_ranked_cache_admission_core.sv =====
// A request without a scan, a reload and unused codes pass through lookup and eval to the result word.
// A request on a full cache, and a load tick with members, go on through the scan of the occupied
// slots, its drain and resolve (plus an admit step when a member is evicted) before the result word.
// One word at a time; the next word is taken in the cycle after the result is staged.
// Reset: asynchronous, active low; afterwards a clearing pass over all NUM_IDS entries zeroes the
// count table while the input stays not ready.
module frequency_ranked_cache_admission_core #(
    parameter int NUM_IDS     = frca_pkg::NUM_IDS_DEF,
    parameter int CACHE_SLOTS = frca_pkg::CACHE_SLOTS_DEF,
    parameter int COUNT_BITS  = frca_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    frca_in_if.sink     req,
    frca_out_if.source  rsp
);

    // Controller and datapath talk only through these two groups
    frca_pkg::cmd_t    cmd;
    frca_pkg::status_t status;

    // Sequencer: clearing pass, lookup, slot scan, resolve, hand the word over
    frca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Count/flag table, slot table, scan pipeline and the output register; the output
    // register holds a finished word so the next request word can be accepted meanwhile
    frca_dp #(
        .NUM_IDS     (NUM_IDS),
        .CACHE_SLOTS (CACHE_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_func       (req.func),
        .in_item_id    (req.item_id),
        .fetch_valid   (rsp.fetch_valid),
        .fetch_id      (rsp.fetch_id),
        .release_valid (rsp.release_valid),
        .release_id    (rsp.release_id)
    );

endmodule

// ===== design/frca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module frca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/frca_ctrl.sv =====
// Sequencing state machine of the cache admission core.
module frca_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  frca_pkg::status_t status,
    output frca_pkg::cmd_t    cmd
);

    frca_pkg::state_t state_reg;
    frca_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frca_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frca_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = frca_pkg::ST_IDLE;
                end
            end
            frca_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = frca_pkg::ST_LOOKUP;
                end
            end
            frca_pkg::ST_LOOKUP:
            begin
                state_next = frca_pkg::ST_EVAL;
            end
            frca_pkg::ST_EVAL:
            begin
                state_next = status.eval_scan ? frca_pkg::ST_SCAN : frca_pkg::ST_DONE;
            end
            frca_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = frca_pkg::ST_DRAIN;
                end
            end
            frca_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = frca_pkg::ST_RESOLVE;
                end
            end
            frca_pkg::ST_RESOLVE:
            begin
                state_next = status.resolve_admit ? frca_pkg::ST_ADMIT : frca_pkg::ST_DONE;
            end
            frca_pkg::ST_ADMIT:
            begin
                state_next = frca_pkg::ST_DONE;
            end
            frca_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = frca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frca_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            frca_pkg::ST_CLEAR:   cmd.clr_step = 1'b1;
            frca_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            frca_pkg::ST_EVAL:
            begin
                cmd.eval      = 1'b1;
                cmd.scan_init = 1'b1;
            end
            frca_pkg::ST_SCAN:    cmd.scan_issue = 1'b1;
            frca_pkg::ST_RESOLVE: cmd.resolve    = 1'b1;
            frca_pkg::ST_ADMIT:   cmd.admit_new  = 1'b1;
            frca_pkg::ST_DONE:    cmd.load_out   = out_free;
            default:              cmd            = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

// ===== design/frca_dp.sv =====
// Datapath: count/flag table, slot table, slot scan pipeline and result registers.
module frca_dp #(
    parameter int NUM_IDS     = frca_pkg::NUM_IDS_DEF,
    parameter int CACHE_SLOTS = frca_pkg::CACHE_SLOTS_DEF,
    parameter int COUNT_BITS  = frca_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  frca_pkg::cmd_t              cmd,
    output frca_pkg::status_t           status,
    input  logic [frca_pkg::FUNC_W-1:0] in_func,
    input  logic [frca_pkg::ITEM_W-1:0] in_item_id,
    output logic                        fetch_valid,
    output logic [frca_pkg::ITEM_W-1:0] fetch_id,
    output logic                        release_valid,
    output logic [frca_pkg::ITEM_W-1:0] release_id
);

    localparam int ID_W    = $clog2(NUM_IDS);
    localparam int SLOT_W  = $clog2(CACHE_SLOTS);
    localparam int SLOT_CW = $clog2(CACHE_SLOTS + 1);
    localparam int EW      = COUNT_BITS + 2;
    localparam int MEMB    = COUNT_BITS + 1;
    localparam int PEND    = COUNT_BITS;

    // entry word: {member, pending, count}
    logic            ent_we;
    logic [ID_W-1:0] ent_waddr;
    logic [EW-1:0]   ent_wdata;
    logic [ID_W-1:0] ent_raddr;
    logic [EW-1:0]   ent_rdata;

    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [ID_W-1:0]   slot_wdata;
    logic [ID_W-1:0]   slot_rdata;

    logic [ID_W-1:0]              clr_addr_reg;
    logic [frca_pkg::FUNC_W-1:0]  func_reg;
    logic [ID_W-1:0]              id_reg;
    logic [COUNT_BITS-1:0]        cnt_reg;
    logic [COUNT_BITS-1:0]        thr_reg;
    logic [SLOT_CW-1:0]           used_reg;
    logic [SLOT_CW-1:0]           scan_cnt_reg;
    logic                         s1_valid_reg;
    logic [SLOT_W-1:0]            s1_idx_reg;
    logic                         s2_valid_reg;
    logic [SLOT_W-1:0]            s2_idx_reg;
    logic [ID_W-1:0]              s2_id_reg;
    logic [COUNT_BITS-1:0]        least_reg;
    logic [COUNT_BITS-1:0]        second_reg;
    logic [SLOT_W-1:0]            lslot_reg;
    logic [ID_W-1:0]              vid_reg;
    logic                         vpend_reg;
    logic                         found_reg;
    logic                         res_fv_reg;
    logic [ID_W-1:0]              res_fid_reg;
    logic                         res_rv_reg;
    logic [ID_W-1:0]              res_rid_reg;
    logic                         out_fv_reg;
    logic [ID_W-1:0]              out_fid_reg;
    logic                         out_rv_reg;
    logic [ID_W-1:0]              out_rid_reg;

    logic [frca_pkg::ITEM_W-1:0] rem;
    logic [ID_W-1:0]             id_in;
    logic [COUNT_BITS-1:0]       cur_cnt;
    logic                        cur_memb;
    logic                        cur_pend;
    logic [COUNT_BITS-1:0]       cnt_new;
    logic                        admit;
    logic                        has_free;
    logic                        replace;

    frca_ram #(.WIDTH(EW), .DEPTH(NUM_IDS)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    frca_ram #(.WIDTH(ID_W), .DEPTH(CACHE_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (scan_cnt_reg[SLOT_W-1:0]),
        .rdata (slot_rdata)
    );

    // Reduce the item id into the id range by restoring subtraction
    always_comb
    begin
        rem = in_item_id;
        for (int k = frca_pkg::ITEM_W - 1; k >= 0; k--)
        begin
            if (32'(rem) >= (32'(NUM_IDS) << k))
            begin
                rem = rem - frca_pkg::ITEM_W'(32'(NUM_IDS) << k);
            end
        end
        id_in = ID_W'(rem);
    end

    assign cur_cnt  = ent_rdata[COUNT_BITS-1:0];
    assign cur_memb = ent_rdata[MEMB];
    assign cur_pend = ent_rdata[PEND];
    assign cnt_new  = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
    assign admit    = (cnt_new > thr_reg) && !cur_memb;
    assign has_free = used_reg < SLOT_CW'(CACHE_SLOTS);
    assign replace  = least_reg < cnt_reg;

    assign ent_raddr = s1_valid_reg ? slot_rdata : id_reg;

    always_comb
    begin
        status               = '0;
        status.clr_last      = clr_addr_reg == ID_W'(NUM_IDS - 1);
        status.eval_scan     = ((func_reg == frca_pkg::FUNC_REQUEST) && admit && !has_free)
                            || ((func_reg == frca_pkg::FUNC_TICK) && (used_reg != '0));
        status.scan_last     = (scan_cnt_reg + 1'b1) == used_reg;
        status.pipe_busy     = s1_valid_reg || s2_valid_reg;
        status.resolve_admit = (func_reg == frca_pkg::FUNC_REQUEST) && replace;
    end

    // Table write selection
    always_comb
    begin
        ent_we     = 1'b0;
        ent_waddr  = id_reg;
        ent_wdata  = '0;
        slot_we    = 1'b0;
        slot_waddr = used_reg[SLOT_W-1:0];
        slot_wdata = id_reg;
        if (cmd.clr_step)
        begin
            ent_we    = 1'b1;
            ent_waddr = clr_addr_reg;
        end
        else if (cmd.eval)
        begin
            if (func_reg == frca_pkg::FUNC_REQUEST)
            begin
                ent_we    = 1'b1;
                ent_wdata = {cur_memb | (admit && has_free), cur_pend, cnt_new};
                slot_we   = admit && has_free;
            end
            else if (func_reg == frca_pkg::FUNC_RELOAD)
            begin
                ent_we    = cur_memb && !cur_pend;
                ent_wdata = {1'b1, 1'b1, cur_cnt};
            end
        end
        else if (cmd.resolve)
        begin
            ent_waddr = vid_reg;
            if (func_reg == frca_pkg::FUNC_REQUEST)
            begin
                ent_we     = replace;
                ent_wdata  = {1'b0, 1'b0, least_reg};
                slot_we    = replace;
                slot_waddr = lslot_reg;
            end
            else
            begin
                ent_we    = found_reg;
                ent_wdata = {1'b1, 1'b0, least_reg};
            end
        end
        else if (cmd.admit_new)
        begin
            ent_we    = 1'b1;
            ent_wdata = {1'b1, 1'b0, cnt_reg};
        end
    end

    // Control state: clear sweep, occupancy, threshold, scan pipeline valids, found flag, output valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            thr_reg      <= '0;
            used_reg     <= '0;
            scan_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            out_fv_reg   <= 1'b0;
            out_rv_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.eval && (func_reg == frca_pkg::FUNC_REQUEST) && admit && has_free)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.resolve && (func_reg == frca_pkg::FUNC_REQUEST))
            begin
                if (replace)
                begin
                    thr_reg <= (second_reg > cnt_reg) ? cnt_reg : second_reg;
                end
                else
                begin
                    thr_reg <= least_reg;
                end
            end
            if (cmd.scan_init)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            s1_valid_reg <= cmd.scan_issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.scan_init)
            begin
                found_reg <= 1'b0;
            end
            else if (s2_valid_reg && (func_reg == frca_pkg::FUNC_TICK) && cur_pend)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_fv_reg <= res_fv_reg;
                out_rv_reg <= res_rv_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            id_reg   <= id_in;
        end
        if (cmd.eval)
        begin
            cnt_reg     <= cnt_new;
            res_fv_reg  <= 1'b0;
            res_fid_reg <= id_reg;
            res_rv_reg  <= 1'b0;
            res_rid_reg <= id_reg;
            if ((func_reg == frca_pkg::FUNC_REQUEST) && admit && has_free)
            begin
                res_fv_reg <= 1'b1;
            end
            if ((func_reg == frca_pkg::FUNC_RELOAD) && cur_memb && !cur_pend)
            begin
                res_rv_reg <= 1'b1;
            end
        end
        if (cmd.resolve)
        begin
            res_fv_reg  <= 1'b0;
            res_rv_reg  <= 1'b0;
            res_fid_reg <= id_reg;
            res_rid_reg <= vid_reg;
            if (func_reg == frca_pkg::FUNC_REQUEST)
            begin
                res_fv_reg <= replace;
                res_rv_reg <= replace && !vpend_reg;
            end
            else
            begin
                res_fv_reg  <= found_reg;
                res_fid_reg <= vid_reg;
            end
        end
        s1_idx_reg <= scan_cnt_reg[SLOT_W-1:0];
        s2_idx_reg <= s1_idx_reg;
        s2_id_reg  <= slot_rdata;
        if (s2_valid_reg)
        begin
            if (func_reg == frca_pkg::FUNC_REQUEST)
            begin
                if (s2_idx_reg == '0)
                begin
                    least_reg  <= cur_cnt;
                    second_reg <= '1;
                    lslot_reg  <= s2_idx_reg;
                    vid_reg    <= s2_id_reg;
                    vpend_reg  <= cur_pend;
                end
                else if (cur_cnt < least_reg)
                begin
                    second_reg <= least_reg;
                    least_reg  <= cur_cnt;
                    lslot_reg  <= s2_idx_reg;
                    vid_reg    <= s2_id_reg;
                    vpend_reg  <= cur_pend;
                end
                else if (cur_cnt < second_reg)
                begin
                    second_reg <= cur_cnt;
                end
            end
            else if (!found_reg && cur_pend)
            begin
                // first pending member in slot order
                least_reg <= cur_cnt;
                vid_reg   <= s2_id_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_fid_reg <= res_fid_reg;
            out_rid_reg <= res_rid_reg;
        end
    end

    assign fetch_valid   = out_fv_reg;
    assign fetch_id      = out_fv_reg ? frca_pkg::ITEM_W'(out_fid_reg) : '0;
    assign release_valid = out_rv_reg;
    assign release_id    = out_rv_reg ? frca_pkg::ITEM_W'(out_rid_reg) : '0;

endmodule
